>>> src/hdc_pkg.sv
// Shared constants, types and codes of the hierarchical depth cull block.
package hdc_pkg;

  localparam int unsigned DEF_SIDE_LOG2  = 6;
  localparam int unsigned DEF_DEPTH_BITS = 24;

  // Widths of the fixed stream fields.
  localparam int unsigned COORD_W     = 12;
  localparam int unsigned ZIN_W       = 24;
  localparam int unsigned VERT_W      = 2 * COORD_W + ZIN_W;
  localparam int unsigned IN_TDATA_W  = 3 * VERT_W;
  localparam int unsigned IN_TUSER_W  = 1;
  localparam int unsigned OUT_TDATA_W = 8;

  // Opcode carried in tuser.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_W_LEAF,
    ST_W_RD0,
    ST_W_RD1,
    ST_W_RD2,
    ST_W_LAST,
    ST_Q_RD,
    ST_Q_CMP
  } hdc_state_e;

  // Which sibling of the current node is read.
  typedef enum logic [1:0] {
    SIB_X,
    SIB_Y,
    SIB_XY
  } hdc_sib_e;

  typedef struct packed {
    logic     capture;
    logic     clr_step;
    logic     leaf_wr;
    logic     sib_rd;
    hdc_sib_e sib;
    logic     acc_first;
    logic     acc_next;
    logic     par_wr;
    logic     q_rd;
    logic     q_done;
  } hdc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic lvl_one;
  } hdc_status_t;

endpackage

>>> src/hdc_ctrl.sv
// Controller state machine of the hierarchical depth cull block.
module hdc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  hdc_pkg::hdc_status_t status_i,
  output hdc_pkg::hdc_cmd_t    cmd_o
);
  import hdc_pkg::*;

  hdc_state_e state_q, state_d;
  logic       m_valid_q, m_valid_d;
  logic       out_free;

  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (status_i.clr_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = (s_axis_tuser == OP_QUERY) ? ST_Q_RD : ST_W_LEAF;
        end
      end
      ST_W_LEAF: state_d = ST_W_RD0;
      ST_W_RD0:  state_d = ST_W_RD1;
      ST_W_RD1:  state_d = ST_W_RD2;
      ST_W_RD2:  state_d = ST_W_LAST;
      ST_W_LAST: state_d = status_i.lvl_one ? ST_IDLE : ST_W_RD0;
      ST_Q_RD:   state_d = ST_Q_CMP;
      ST_Q_CMP:  if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.sib     = SIB_X;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.capture = s_axis_tvalid;
      end
      ST_W_LEAF: cmd_o.leaf_wr = 1'b1;
      ST_W_RD0: begin
        cmd_o.sib_rd = 1'b1;
        cmd_o.sib    = SIB_X;
      end
      ST_W_RD1: begin
        cmd_o.sib_rd    = 1'b1;
        cmd_o.sib       = SIB_Y;
        cmd_o.acc_first = 1'b1;
      end
      ST_W_RD2: begin
        cmd_o.sib_rd   = 1'b1;
        cmd_o.sib      = SIB_XY;
        cmd_o.acc_next = 1'b1;
      end
      ST_W_LAST: cmd_o.par_wr = 1'b1;
      ST_Q_RD:   cmd_o.q_rd   = 1'b1;
      ST_Q_CMP:  cmd_o.q_done = out_free;
      default: ;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.q_done) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;

`ifndef SYNTHESIS
  a_done_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.q_done |-> (!m_valid_q || m_axis_tready))
    else $error("query result loaded while the output slot is occupied");

  a_query_starts_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_QUERY)) |=> state_q == ST_Q_RD)
    else $error("accepted query did not start its node read");

  a_result_from_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q) == ST_Q_CMP)
    else $error("result raised outside the compare step");
`endif

endmodule

>>> src/hdc_datapath.sv
// Datapath of the hierarchical depth cull block: item registers, node memory and min/compare.
module hdc_datapath #(
  parameter int unsigned SIDE_LOG2  = hdc_pkg::DEF_SIDE_LOG2,
  parameter int unsigned DEPTH_BITS = hdc_pkg::DEF_DEPTH_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [hdc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic [hdc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  hdc_pkg::hdc_cmd_t                 cmd_i,
  output hdc_pkg::hdc_status_t              status_o
);
  import hdc_pkg::*;

  localparam int unsigned SIDE       = 1 << SIDE_LOG2;
  localparam int unsigned NODE_COUNT = ((1 << (2 * (SIDE_LOG2 + 1))) - 1) / 3;
  localparam int unsigned AW         = $clog2(NODE_COUNT);
  localparam int unsigned LW         = $clog2(SIDE_LOG2 + 1);

  typedef logic [SIDE_LOG2-1:0]  coord_t;
  typedef logic [DEPTH_BITS-1:0] depth_t;
  typedef logic [AW-1:0]         addr_t;
  typedef logic [LW-1:0]         lvl_t;

  function automatic coord_t clamp_coord(input logic [COORD_W-1:0] c);
    coord_t r;
    if (c[COORD_W-1]) begin
      r = '0;
    end else if (c[COORD_W-2:0] > (COORD_W-1)'(SIDE - 1)) begin
      r = '1;
    end else begin
      r = c[SIDE_LOG2-1:0];
    end
    return r;
  endfunction

  function automatic depth_t sat_depth(input logic [ZIN_W-1:0] z);
    logic signed [32:0] zx, hi, lo;
    zx = {{(33 - ZIN_W){z[ZIN_W-1]}}, z};
    hi = (33'sd1 <<< (DEPTH_BITS - 1)) - 33'sd1;
    lo = -(33'sd1 <<< (DEPTH_BITS - 1));
    if (zx > hi) begin
      zx = hi;
    end else if (zx < lo) begin
      zx = lo;
    end
    return zx[DEPTH_BITS-1:0];
  endfunction

  function automatic depth_t min_depth(input depth_t a, input depth_t b);
    return ($signed(a) < $signed(b)) ? a : b;
  endfunction

  // First node of a level: the sum of 4^k over the levels above it.
  function automatic addr_t level_base(input lvl_t lvl);
    addr_t b;
    b = '0;
    for (int k = 0; k < SIDE_LOG2; k++) begin
      if (lvl_t'(k) < lvl) b = b | (addr_t'(1) << (2 * k));
    end
    return b;
  endfunction

  function automatic addr_t node_addr(input lvl_t lvl, input coord_t x, input coord_t y);
    return level_base(lvl) + (addr_t'(y) << lvl) + addr_t'(x);
  endfunction

  // Item registers.
  coord_t xa_q, ya_q, xb_q, yb_q, xc_q, yc_q;
  depth_t za_q, zb_q, zc_q;

  // Write walk, query and clear registers.
  coord_t xl_q, yl_q;
  lvl_t   lvl_q;
  depth_t cur_q, acc_q, near_q;
  addr_t  clr_q;
  logic   vis_q;

  // Node memory.
  depth_t mem_q [NODE_COUNT];
  depth_t rd_q;
  logic   we, re;
  addr_t  wa, ra;
  depth_t wd;

  depth_t par_val;
  coord_t sib_x, sib_y;
  coord_t diff;
  lvl_t   q_shift;
  addr_t  q_addr;
  depth_t max_ab, max_abc;

  assign par_val = min_depth(acc_q, rd_q);

  always_comb begin
    sib_x = xl_q;
    sib_y = yl_q;
    unique case (cmd_i.sib)
      SIB_X:  sib_x = {xl_q[SIDE_LOG2-1:1], ~xl_q[0]};
      SIB_Y:  sib_y = {yl_q[SIDE_LOG2-1:1], ~yl_q[0]};
      SIB_XY: begin
        sib_x = {xl_q[SIDE_LOG2-1:1], ~xl_q[0]};
        sib_y = {yl_q[SIDE_LOG2-1:1], ~yl_q[0]};
      end
      default: ;
    endcase
  end

  // The common ancestor sits above the highest coordinate bit in which the vertices differ.
  always_comb begin
    diff    = (xa_q ^ xb_q) | (xa_q ^ xc_q) | (ya_q ^ yb_q) | (ya_q ^ yc_q);
    q_shift = '0;
    for (int k = 0; k < SIDE_LOG2; k++) begin
      if (diff[k]) q_shift = lvl_t'(k + 1);
    end
    q_addr = node_addr(lvl_t'(SIDE_LOG2) - q_shift, xa_q >> q_shift, ya_q >> q_shift);
  end

  assign max_ab  = ($signed(za_q) > $signed(zb_q)) ? za_q : zb_q;
  assign max_abc = ($signed(max_ab) > $signed(zc_q)) ? max_ab : zc_q;

  always_comb begin
    we = 1'b0;
    wa = clr_q;
    wd = {1'b1, {(DEPTH_BITS - 1){1'b0}}};
    priority if (cmd_i.clr_step) begin
      we = 1'b1;
    end else if (cmd_i.leaf_wr) begin
      we = 1'b1;
      wa = node_addr(lvl_t'(SIDE_LOG2), xl_q, yl_q);
      wd = za_q;
    end else if (cmd_i.par_wr) begin
      we = 1'b1;
      wa = node_addr(lvl_q - lvl_t'(1), xl_q >> 1, yl_q >> 1);
      wd = par_val;
    end
  end

  assign re = cmd_i.sib_rd || cmd_i.q_rd;
  assign ra = cmd_i.q_rd ? q_addr : node_addr(lvl_q, sib_x, sib_y);

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    if (re) rd_q <= mem_q[ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      xa_q <= clamp_coord(s_axis_tdata[0 +: COORD_W]);
      ya_q <= clamp_coord(s_axis_tdata[COORD_W +: COORD_W]);
      za_q <= sat_depth(s_axis_tdata[2 * COORD_W +: ZIN_W]);
      xb_q <= clamp_coord(s_axis_tdata[VERT_W +: COORD_W]);
      yb_q <= clamp_coord(s_axis_tdata[VERT_W + COORD_W +: COORD_W]);
      zb_q <= sat_depth(s_axis_tdata[VERT_W + 2 * COORD_W +: ZIN_W]);
      xc_q <= clamp_coord(s_axis_tdata[2 * VERT_W +: COORD_W]);
      yc_q <= clamp_coord(s_axis_tdata[2 * VERT_W + COORD_W +: COORD_W]);
      zc_q <= sat_depth(s_axis_tdata[2 * VERT_W + 2 * COORD_W +: ZIN_W]);
      xl_q <= clamp_coord(s_axis_tdata[0 +: COORD_W]);
      yl_q <= clamp_coord(s_axis_tdata[COORD_W +: COORD_W]);
    end else if (cmd_i.par_wr) begin
      xl_q <= xl_q >> 1;
      yl_q <= yl_q >> 1;
    end
    if (cmd_i.leaf_wr) cur_q <= za_q;
    else if (cmd_i.par_wr) cur_q <= par_val;
    if (cmd_i.acc_first) acc_q <= min_depth(cur_q, rd_q);
    else if (cmd_i.acc_next) acc_q <= min_depth(acc_q, rd_q);
    if (cmd_i.q_rd) near_q <= max_abc;
    if (cmd_i.q_done) vis_q <= !($signed(near_q) < $signed(rd_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      lvl_q <= '0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + addr_t'(1);
      if (cmd_i.leaf_wr) lvl_q <= lvl_t'(SIDE_LOG2);
      else if (cmd_i.par_wr) lvl_q <= lvl_q - lvl_t'(1);
    end
  end

  assign status_o.clr_last = (clr_q == addr_t'(NODE_COUNT - 1));
  assign status_o.lvl_one  = (lvl_q == lvl_t'(1));
  assign m_axis_tdata      = {{(OUT_TDATA_W - 1){1'b0}}, vis_q};

`ifndef SYNTHESIS
  a_parent_below_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.par_wr |-> lvl_q != '0)
    else $error("parent write attempted above the root");

  a_leaf_sets_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.leaf_wr |=> lvl_q == lvl_t'(SIDE_LOG2))
    else $error("leaf write did not start the walk at the leaf level");
`endif

endmodule

>>> src/hierarchical_depth_cull.sv
// Top level of the hierarchical depth cull block.
// The block keeps a quadtree of farthest depths over a 2^SIDE_LOG2 square grid and
// culls triangles against it. Items arrive on the s_axis channel; tuser selects a
// depth write (0) or a triangle query (1). A write produces no result; a query
// produces one is_visible bit on the m_axis channel.
// A query passes through a read step and a compare step before the next acceptance;
// its result is registered as the compare step ends, and the query costs one read of
// the node memory. A write stores the leaf, then for each level reads the three
// siblings through the single read port and writes the parent.
// After reset the node memory is cleared to minus infinity, one node a cycle, over all
// (4^(SIDE_LOG2+1) - 1) / 3 nodes (5461 at the default size); s_axis_tready
// stays low meanwhile.
// The result sits in an output register, so a new item is accepted while it waits.
// If the receiver stalls, a following query holds in its compare step until the
// slot is taken; writes proceed regardless.
module hierarchical_depth_cull #(
  parameter int unsigned SIDE_LOG2  = hdc_pkg::DEF_SIDE_LOG2,
  parameter int unsigned DEPTH_BITS = hdc_pkg::DEF_DEPTH_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Fields from bit 0: x_a, y_a, z_a, x_b, y_b, z_b, x_c, y_c, z_c.
  input  logic [hdc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0: opcode.
  input  logic [hdc_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Fields from bit 0: is_visible, then zero padding.
  output logic [hdc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import hdc_pkg::*;

  hdc_cmd_t    cmd;
  hdc_status_t status;

  hdc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser[0]),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  hdc_datapath #(
    .SIDE_LOG2  (SIDE_LOG2),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tdata (m_axis_tdata),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the hierarchical depth cull block.
`timescale 1ns / 100ps

module testbench;
  import hdc_pkg::*;

  localparam int SIDE_LOG2      = DEF_SIDE_LOG2;
  localparam int DEPTH_BITS     = DEF_DEPTH_BITS;
  localparam int SIDE           = 1 << SIDE_LOG2;
  localparam int NODE_TOTAL     = ((1 << (2 * (SIDE_LOG2 + 1))) - 1) / 3;
  localparam int WRITE_CYCLES   = 4 * SIDE_LOG2 + 2;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 197;
  localparam int ZMIN           = -(1 << (ZIN_W - 1));
  localparam int ZMAX           = (1 << (ZIN_W - 1)) - 1;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_RANDOM,
    RX_BLOCKY
  } rx_mode_e;

  typedef struct packed {
    logic                      op;
    logic signed [COORD_W-1:0] x_a;
    logic signed [COORD_W-1:0] y_a;
    logic signed [ZIN_W-1:0]   z_a;
    logic signed [COORD_W-1:0] x_b;
    logic signed [COORD_W-1:0] y_b;
    logic signed [ZIN_W-1:0]   z_b;
    logic signed [COORD_W-1:0] x_c;
    logic signed [COORD_W-1:0] y_c;
    logic signed [ZIN_W-1:0]   z_c;
  } cull_item_t;

  // Keeps its own depth quadtree and the queue of visibility verdicts still to come.
  class cull_tracker;
    logic signed [DEPTH_BITS-1:0] depth_tree [NODE_TOTAL];
    bit                           visible_due [$];
    int unsigned                  errors;

    function new();
      foreach (depth_tree[k]) depth_tree[k] = {1'b1, {(DEPTH_BITS - 1){1'b0}}};
      errors = 0;
    endfunction

    function int unsigned pending();
      return visible_due.size();
    endfunction

    function int unsigned node_at(int unsigned level, int unsigned i, int unsigned j);
      return ((1 << (2 * level)) - 1) / 3 + j * (1 << level) + i;
    endfunction

    function int unsigned clamp_xy(logic signed [COORD_W-1:0] c);
      int v;
      v = c;
      if (v < 0) return 0;
      if (v > SIDE - 1) return SIDE - 1;
      return v;
    endfunction

    function logic signed [DEPTH_BITS-1:0] sat_depth(logic signed [ZIN_W-1:0] z);
      longint v;
      longint lo;
      longint hi;
      v  = z;
      lo = -(longint'(1) << (DEPTH_BITS - 1));
      hi = (longint'(1) << (DEPTH_BITS - 1)) - 1;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return DEPTH_BITS'(v);
    endfunction

    function logic signed [DEPTH_BITS-1:0] lower(logic signed [DEPTH_BITS-1:0] a,
                                                 logic signed [DEPTH_BITS-1:0] b);
      return (a < b) ? a : b;
    endfunction

    function void accept_item(cull_item_t it);
      int unsigned                  xa, ya, xb, yb, xc, yc;
      int unsigned                  s, lvl, px, py;
      logic signed [DEPTH_BITS-1:0] za, zb, zc, nearest, node;
      xa = clamp_xy(it.x_a);
      ya = clamp_xy(it.y_a);
      za = sat_depth(it.z_a);
      if (it.op == OP_WRITE) begin
        depth_tree[node_at(SIDE_LOG2, xa, ya)] = za;
        // Rebuild each ancestor from its four children, leaf level upwards.
        for (lvl = SIDE_LOG2; lvl > 0; lvl--) begin
          s  = SIDE_LOG2 - lvl + 1;
          px = xa >> s;
          py = ya >> s;
          depth_tree[node_at(lvl - 1, px, py)] =
            lower(lower(depth_tree[node_at(lvl, 2 * px, 2 * py)],
                        depth_tree[node_at(lvl, 2 * px + 1, 2 * py)]),
                  lower(depth_tree[node_at(lvl, 2 * px, 2 * py + 1)],
                        depth_tree[node_at(lvl, 2 * px + 1, 2 * py + 1)]));
        end
      end else begin
        xb = clamp_xy(it.x_b);
        yb = clamp_xy(it.y_b);
        zb = sat_depth(it.z_b);
        xc = clamp_xy(it.x_c);
        yc = clamp_xy(it.y_c);
        zc = sat_depth(it.z_c);
        nearest = za;
        if (zb > nearest) nearest = zb;
        if (zc > nearest) nearest = zc;
        // Climb until one node covers all three vertices.
        s = 0;
        while (s < SIDE_LOG2 &&
               !((xa >> s) == (xb >> s) && (xa >> s) == (xc >> s) &&
                 (ya >> s) == (yb >> s) && (ya >> s) == (yc >> s)))
          s++;
        node = depth_tree[node_at(SIDE_LOG2 - s, xa >> s, ya >> s)];
        visible_due.push_back(!(nearest < node));
      end
    endfunction

    function void check_visible(logic visible);
      bit want;
      if (visible_due.size() == 0) begin
        $error("is_visible: no result expected, actual %0b", visible);
        errors++;
      end else begin
        want = visible_due.pop_front();
        if (visible !== want) begin
          $error("is_visible mismatch: expected %0b, actual %0b", want, visible);
          errors++;
        end
      end
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                   m_axis_tready = 1'b0;
  wire                    s_axis_tready;
  wire                    m_axis_tvalid;
  wire [OUT_TDATA_W-1:0]  m_axis_tdata;

  cull_tracker tracker;
  rx_mode_e    ready_mode  = RX_RANDOM;
  int unsigned ready_tick  = 0;
  int unsigned quiet_cycles = 0;
  bit          gaps_on     = 1'b1;
  int unsigned burst_left  = 1;

  hierarchical_depth_cull #(
    .SIDE_LOG2 (SIDE_LOG2),
    .DEPTH_BITS(DEPTH_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    ready_tick <= ready_tick + 1;
    case (ready_mode)
      RX_STEADY: m_axis_tready <= 1'b1;
      RX_RANDOM: m_axis_tready <= ($urandom_range(0, 2) != 0);
      default:   m_axis_tready <= (ready_tick % 23) >= 15;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_visible(m_axis_tdata[0]);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    do @(posedge clk_i); while (quiet_cycles < WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  function automatic cull_item_t tri_item(logic op, int xa, int ya, int za,
                                          int xb, int yb, int zb,
                                          int xc, int yc, int zc);
    cull_item_t it;
    it.op  = op;
    it.x_a = COORD_W'(xa);
    it.y_a = COORD_W'(ya);
    it.z_a = ZIN_W'(za);
    it.x_b = COORD_W'(xb);
    it.y_b = COORD_W'(yb);
    it.z_b = ZIN_W'(zb);
    it.x_c = COORD_W'(xc);
    it.y_c = COORD_W'(yc);
    it.z_c = ZIN_W'(zc);
    return it;
  endfunction

  task automatic send_item(input cull_item_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= {it.z_c, it.y_c, it.x_c, it.z_b, it.y_b, it.x_b,
                      it.z_a, it.y_a, it.x_a};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.accept_item(it);
    if (gaps_on) begin
      burst_left--;
      if (burst_left == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  // Holds the sender off until every outstanding verdict has been taken.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int         ox, oy, span, base, pick;
    cull_item_t it;
    tracker    = new();
    burst_left = $urandom_range(1, 16);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: an empty tree, clamped corners, extreme depths, a filled 2x2 block.
    send_item(tri_item(OP_QUERY, 0, 0, ZMIN, 63, 63, ZMIN, 5, 9, ZMIN));
    send_item(tri_item(OP_WRITE, -2048, -2048, 100, 7, 7, 7, 7, 7, 7));
    send_item(tri_item(OP_WRITE, 2047, 2047, ZMAX, 0, 0, 0, 0, 0, 0));
    send_item(tri_item(OP_WRITE, 64, -1, ZMIN, -1, -1, -1, -1, -1, -1));
    send_item(tri_item(OP_QUERY, 0, 0, 99, -1, -7, 99, 0, 0, 98));
    send_item(tri_item(OP_QUERY, 0, 0, 100, 0, 0, ZMIN, 0, 0, -5));
    send_item(tri_item(OP_QUERY, 63, 63, ZMAX - 1, 100, 2047, ZMAX - 1, 63, 63, ZMIN));
    send_item(tri_item(OP_QUERY, 63, 63, ZMAX, 63, 63, ZMAX, 63, 63, ZMAX));
    send_item(tri_item(OP_QUERY, 63, 0, ZMIN, 2047, -2048, 0, 63, 0, ZMIN));
    send_item(tri_item(OP_WRITE, 2, 4, 50, 0, 0, 0, 0, 0, 0));
    send_item(tri_item(OP_WRITE, 3, 4, 60, 0, 0, 0, 0, 0, 0));
    send_item(tri_item(OP_WRITE, 2, 5, 70, 0, 0, 0, 0, 0, 0));
    send_item(tri_item(OP_WRITE, 3, 5, 80, 0, 0, 0, 0, 0, 0));
    send_item(tri_item(OP_QUERY, 2, 4, 49, 3, 5, -300, 3, 4, ZMIN));
    send_item(tri_item(OP_QUERY, 2, 4, 49, 3, 5, 50, 2, 5, 0));
    send_item(tri_item(OP_QUERY, 2, 4, 40, 2, 4, 10, 2, 4, 45));
    send_item(tri_item(OP_QUERY, -2048, 2047, 0, 2047, -2048, 1, 0, 0, 2));
    send_item(tri_item(OP_WRITE, 3, 5, -100, -1, -1, -1, -1, -1, -1));
    send_item(tri_item(OP_QUERY, 2, 4, -101, 3, 5, -200, 3, 4, -150));
    send_item(tri_item(OP_QUERY, 2, 4, -100, 3, 5, -200, 3, 4, -150));
    send_item(tri_item(OP_QUERY, 1, 1, ZMIN, 2, 2, ZMIN, 0, 3, ZMIN));
    drain_results();

    // Random part: each phase works a small window so that upper nodes fill up and cull.
    for (int phase = 0; phase < PHASES; phase++) begin
      ready_mode = rx_mode_e'(phase % 3);
      gaps_on    = (phase % 3) != 0;
      span       = 2 << $urandom_range(0, 2);
      ox         = $urandom_range(0, SIDE / span - 1) * span;
      oy         = $urandom_range(0, SIDE / span - 1) * span;
      base       = int'($urandom_range(0, 4000)) - 2000;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          it = tri_item(OP_WRITE, ox + $urandom_range(0, span - 1),
                        oy + $urandom_range(0, span - 1),
                        ($urandom_range(0, 19) == 0) ? int'($urandom)
                          : base + int'($urandom_range(0, 400)) - 200,
                        $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 88) begin
          it = tri_item(OP_QUERY,
                        ox + $urandom_range(0, span - 1), oy + $urandom_range(0, span - 1),
                        base + int'($urandom_range(0, 600)) - 400,
                        ox + $urandom_range(0, span - 1), oy + $urandom_range(0, span - 1),
                        base + int'($urandom_range(0, 600)) - 400,
                        ox + $urandom_range(0, span - 1), oy + $urandom_range(0, span - 1),
                        base + int'($urandom_range(0, 600)) - 400);
        end else begin
          it = tri_item($urandom_range(0, 1) ? OP_QUERY : OP_WRITE,
                        $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom);
        end
        send_item(it);
        if (k == PHASE_ITEMS / 2) drain_results();
      end
    end

    drain_results();
    repeat (WRITE_CYCLES + 10) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
